@@ rtl/dtau_pkg.sv @@
package dtau_pkg;

	// Exponent codes: 3^0, 3^1, 3^-1. With direction zero, POS and NEG mean +inf and -inf.
	localparam logic [1:0] EXP_ZERO = 2'd0;
	localparam logic [1:0] EXP_POS  = 2'd1;
	localparam logic [1:0] EXP_NEG  = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Scaled magnitudes: values are held as three times their true value.
	localparam logic [4:0] SCALED_ONE   = 5'd1;
	localparam logic [4:0] SCALED_THREE = 5'd3;
	localparam logic [4:0] SCALED_NINE  = 5'd9;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] a_exponent;
		logic [1:0] a_direction;
		logic [1:0] b_exponent;
		logic [1:0] b_direction;
	} req_t;

	typedef struct packed {
		logic [1:0] result_exponent;
		logic [1:0] result_direction;
		logic       divide_by_zero;
	} res_t;

endpackage

@@ rtl/dual_trit_arith_unit_core.sv @@
// Channel   Handshake        Payload   Notes
// request   start, busy      req       transfer when start is high and busy is low
// result    done             result    valid for one cycle, cannot be held off
//
// One operation per clock cycle; busy is never raised.
// A result reaches the result ports after its request transfer and is taken at the edge
// that ends the cycle it is shown in: the request register holds the operands, the result
// register holds the answer.
// Reset clears the stage valid flags only; no result is produced during reset.
// The receiver cannot stall, so nothing ever waits inside the unit.
module dual_trit_arith_unit_core
	import dtau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	req_t req_s1;
	logic valid_s1;
	res_t result_q;
	logic done_q;

	logic [1:0] ae, ad, be, bd;
	logic a_zero, b_zero, a_spec, b_spec, a_neg, b_neg, prod_neg;
	logic signed [4:0] a_scaled, b_scaled;
	logic signed [5:0] sum;
	logic [5:0] sum_mag;
	logic sum_neg;
	logic signed [1:0] a_ev, b_ev;
	logic signed [2:0] ev;
	logic [1:0] re, rd;
	logic dz;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			result_q <= '{result_exponent: re, result_direction: rd, divide_by_zero: dz};
		end
	end

	// Operand decode; a code of three reads as zero.
	always_comb begin
		ae = (req_s1.a_exponent == 2'd3) ? EXP_ZERO : req_s1.a_exponent;
		ad = (req_s1.a_direction == 2'd3) ? DIR_NONE : req_s1.a_direction;
		be = (req_s1.b_exponent == 2'd3) ? EXP_ZERO : req_s1.b_exponent;
		bd = (req_s1.b_direction == 2'd3) ? DIR_NONE : req_s1.b_direction;

		a_zero = (ad == DIR_NONE) && (ae == EXP_ZERO);
		b_zero = (bd == DIR_NONE) && (be == EXP_ZERO);
		a_spec = (ad == DIR_NONE) && (ae != EXP_ZERO);
		b_spec = (bd == DIR_NONE) && (be != EXP_ZERO);
		a_neg  = a_spec ? (ae == EXP_NEG) : (ad == DIR_NEG);
		b_neg  = b_spec ? (be == EXP_NEG) : (bd == DIR_NEG);
		prod_neg = a_neg ^ b_neg;

		a_ev = (ae == EXP_POS) ? 2'sd1 : ((ae == EXP_NEG) ? -2'sd1 : 2'sd0);
		b_ev = (be == EXP_POS) ? 2'sd1 : ((be == EXP_NEG) ? -2'sd1 : 2'sd0);
	end

	// Values times three, with infinity counted as nine.
	always_comb begin
		logic [4:0] a_mag, b_mag;
		if (a_zero) begin
			a_mag = '0;
		end else if (a_spec) begin
			a_mag = SCALED_NINE;
		end else begin
			a_mag = (ae == EXP_NEG) ? SCALED_ONE : ((ae == EXP_POS) ? SCALED_NINE : SCALED_THREE);
		end
		if (b_zero) begin
			b_mag = '0;
		end else if (b_spec) begin
			b_mag = SCALED_NINE;
		end else begin
			b_mag = (be == EXP_NEG) ? SCALED_ONE : ((be == EXP_POS) ? SCALED_NINE : SCALED_THREE);
		end
		a_scaled = a_neg ? -$signed(a_mag) : $signed(a_mag);
		b_scaled = b_neg ? -$signed(b_mag) : $signed(b_mag);
	end

	always_comb begin
		if (req_s1.req_type == OP_SUB) begin
			sum = 6'(a_scaled) - 6'(b_scaled);
		end else begin
			sum = 6'(a_scaled) + 6'(b_scaled);
		end
		sum_neg = sum[5];
		sum_mag = sum_neg ? 6'(-sum) : 6'(sum);
		ev = (req_s1.req_type == OP_DIV) ? 3'(a_ev) - 3'(b_ev) : 3'(a_ev) + 3'(b_ev);
	end

	always_comb begin
		re = EXP_ZERO;
		rd = DIR_NONE;
		dz = 1'b0;
		unique case (req_s1.req_type)
			OP_ADD, OP_SUB: begin
				// Nearest scaled table entry, ties away from zero; nine or more is infinity.
				if (sum_mag >= 6'd9) begin
					re = sum_neg ? EXP_NEG : EXP_POS;
				end else if (sum_mag != 6'd0) begin
					rd = sum_neg ? DIR_NEG : DIR_POS;
					if (sum_mag == 6'd1) begin
						re = EXP_NEG;
					end else if (sum_mag <= 6'd5) begin
						re = EXP_ZERO;
					end else begin
						re = EXP_POS;
					end
				end
			end
			OP_MUL, OP_DIV: begin
				if (req_s1.req_type == OP_DIV && b_zero) begin
					dz = 1'b1;
				end else if (a_zero || (req_s1.req_type == OP_MUL && b_zero)) begin
					re = EXP_ZERO;
				end else if (req_s1.req_type == OP_DIV && a_spec && b_spec) begin
					rd = prod_neg ? DIR_NEG : DIR_POS;
				end else if (req_s1.req_type == OP_DIV && b_spec) begin
					re = EXP_ZERO;
				end else if (a_spec || b_spec || ev > 3'sd1) begin
					re = prod_neg ? EXP_NEG : EXP_POS;
				end else if (ev >= -3'sd1) begin
					re = (ev == 3'sd1) ? EXP_POS : ((ev == -3'sd1) ? EXP_NEG : EXP_ZERO);
					rd = prod_neg ? DIR_NEG : DIR_POS;
				end
			end
			default: begin
				re = EXP_ZERO;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_stage_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request stage did not produce a result");

	a_dz_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_by_zero) |->
			(result.result_exponent == EXP_ZERO && result.result_direction == DIR_NONE))
		else $error("divide by zero result is not zero");

	a_codes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.result_exponent != 2'd3 && result.result_direction != 2'd3))
		else $error("result carries an unused code");
`endif

endmodule

@@ test/tb_dual_trit_arith_unit_core.sv @@
module tb_dual_trit_arith_unit_core;
	import dtau_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RANDOM_OPS = 700;
	localparam int CYCLE_LIMIT = 50000;
	localparam int SETTLE_CYCLES = 4;

	class trit_scoreboard;
		res_t pending[$];
		int errors;

		function logic [1:0] canon(input logic [1:0] c);
			return (c == 2'd3) ? 2'd0 : c;
		endfunction

		// Value times three; infinity counts as nine.
		function int tripled(input logic [1:0] e, input logic [1:0] d);
			int mag;
			if (d == DIR_NONE) begin
				if (e == EXP_POS) return 9;
				if (e == EXP_NEG) return -9;
				return 0;
			end
			mag = (e == EXP_NEG) ? 1 : ((e == EXP_POS) ? 9 : 3);
			return (d == DIR_POS) ? mag : -mag;
		endfunction

		function int sign_of(input logic [1:0] e, input logic [1:0] d);
			if (d == DIR_NONE) begin
				if (e == EXP_POS) return 1;
				if (e == EXP_NEG) return -1;
				return 0;
			end
			return (d == DIR_POS) ? 1 : -1;
		endfunction

		function int power(input logic [1:0] e);
			if (e == EXP_POS) return 1;
			if (e == EXP_NEG) return -1;
			return 0;
		endfunction

		function res_t infinity(input int s);
			res_t y;
			y = '0;
			y.result_exponent = (s > 0) ? EXP_POS : EXP_NEG;
			y.result_direction = DIR_NONE;
			return y;
		endfunction

		// Nearest of 0, 1, 3, 9 (scaled) with ties away from zero; nine stands for the finite
		// value three, yet any magnitude from nine upwards, nine included, rounds to infinity.
		function res_t round_to_format(input int v);
			res_t y;
			int m;
			y = '0;
			m = (v < 0) ? -v : v;
			if (v >= 9) return infinity(1);
			if (v <= -9) return infinity(-1);
			if (m == 0) return y;
			y.result_direction = (v > 0) ? DIR_POS : DIR_NEG;
			if (m == 1) y.result_exponent = EXP_NEG;
			else if (m <= 5) y.result_exponent = EXP_ZERO;
			else y.result_exponent = EXP_POS;
			return y;
		endfunction

		function res_t scale_exp(input int s, input int ev);
			res_t y;
			y = '0;
			if (ev > 1) return infinity(s);
			if (ev < -1) return y;
			y.result_exponent = (ev == 1) ? EXP_POS : ((ev == -1) ? EXP_NEG : EXP_ZERO);
			y.result_direction = (s > 0) ? DIR_POS : DIR_NEG;
			return y;
		endfunction

		function res_t predict(input req_t r);
			logic [1:0] ae, ad, be, bd;
			int sa, sbv;
			bit a_zero, b_zero, a_inf, b_inf;
			res_t y;
			ae = canon(r.a_exponent);
			ad = canon(r.a_direction);
			be = canon(r.b_exponent);
			bd = canon(r.b_direction);
			a_zero = (ad == DIR_NONE && ae == EXP_ZERO);
			b_zero = (bd == DIR_NONE && be == EXP_ZERO);
			a_inf = (ad == DIR_NONE && ae != EXP_ZERO);
			b_inf = (bd == DIR_NONE && be != EXP_ZERO);
			sa = sign_of(ae, ad);
			sbv = sign_of(be, bd);
			y = '0;
			case (r.req_type)
				OP_ADD: y = round_to_format(tripled(ae, ad) + tripled(be, bd));
				OP_SUB: y = round_to_format(tripled(ae, ad) - tripled(be, bd));
				OP_MUL: begin
					if (a_zero || b_zero) y = '0;
					else if (a_inf || b_inf) y = infinity(sa * sbv);
					else y = scale_exp(sa * sbv, power(ae) + power(be));
				end
				OP_DIV: begin
					if (b_zero) y.divide_by_zero = 1'b1;
					else if (a_zero) y = '0;
					else if (a_inf && b_inf)
						y.result_direction = (sa * sbv > 0) ? DIR_POS : DIR_NEG;
					else if (b_inf) y = '0;
					else if (a_inf) y = infinity(sa * sbv);
					else y = scale_exp(sa * sbv, power(ae) - power(be));
				end
				default: ;
			endcase
			return y;
		endfunction

		function void note(input req_t r);
			pending.push_back(predict(r));
		endfunction

		function void check(input res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: exp=%0d dir=%0d dz=%0d",
						got.result_exponent, got.result_direction, got.divide_by_zero);
				return;
			end
			want = pending.pop_front();
			if (got.result_exponent !== want.result_exponent ||
					got.result_direction !== want.result_direction ||
					got.divide_by_zero !== want.divide_by_zero) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected exp=%0d dir=%0d dz=%0d, got exp=%0d dir=%0d dz=%0d",
						want.result_exponent, want.result_direction, want.divide_by_zero,
						got.result_exponent, got.result_direction, got.divide_by_zero);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t result;

	trit_scoreboard sb;
	int cycles;

	dual_trit_arith_unit_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// The request is noted before the result is checked, so the order of the two
	// transfers within one edge does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note(req);
			if (done) sb.check(result);
		end
	end

	function automatic req_t pack_op(input logic [1:0] op, input logic [1:0] ae,
			input logic [1:0] ad, input logic [1:0] be, input logic [1:0] bd);
		req_t r;
		r.req_type = op;
		r.a_exponent = ae;
		r.a_direction = ad;
		r.b_exponent = be;
		r.b_direction = bd;
		return r;
	endfunction

	// Called just after a rising edge; returns just after the edge of the transfer.
	task automatic send_op(input req_t r, input bit allow_gap);
		if (allow_gap && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		req_t r;
		sb = new;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed operations: rounding ties, saturation, flushing, infinities,
		// zero divisors and the unused code three.
		send_op(pack_op(OP_ADD, EXP_POS, DIR_POS, EXP_ZERO, DIR_NONE), 1'b0);
		send_op(pack_op(OP_ADD, EXP_POS, DIR_NONE, EXP_NEG, DIR_NONE), 1'b0);
		send_op(pack_op(OP_ADD, EXP_ZERO, DIR_POS, EXP_ZERO, DIR_POS), 1'b0);
		send_op(pack_op(OP_ADD, EXP_ZERO, DIR_POS, EXP_NEG, DIR_POS), 1'b0);
		send_op(pack_op(OP_ADD, EXP_NEG, DIR_POS, EXP_NEG, DIR_POS), 1'b0);
		send_op(pack_op(OP_SUB, EXP_ZERO, DIR_NEG, EXP_ZERO, DIR_POS), 1'b0);
		send_op(pack_op(OP_SUB, EXP_NEG, DIR_NEG, EXP_NEG, DIR_POS), 1'b0);
		send_op(pack_op(OP_SUB, EXP_NEG, DIR_NONE, EXP_POS, DIR_NONE), 1'b0);
		send_op(pack_op(OP_MUL, EXP_POS, DIR_POS, EXP_POS, DIR_NEG), 1'b0);
		send_op(pack_op(OP_MUL, EXP_NEG, DIR_NEG, EXP_NEG, DIR_NEG), 1'b0);
		send_op(pack_op(OP_MUL, EXP_POS, DIR_NONE, EXP_ZERO, DIR_NONE), 1'b0);
		send_op(pack_op(OP_MUL, EXP_NEG, DIR_NONE, EXP_POS, DIR_POS), 1'b0);
		send_op(pack_op(OP_MUL, EXP_POS, DIR_POS, EXP_NEG, DIR_NEG), 1'b0);
		send_op(pack_op(OP_DIV, EXP_ZERO, DIR_POS, EXP_ZERO, DIR_NONE), 1'b0);
		send_op(pack_op(OP_DIV, EXP_ZERO, DIR_NONE, EXP_ZERO, DIR_NONE), 1'b0);
		send_op(pack_op(OP_DIV, EXP_POS, DIR_NONE, EXP_NEG, DIR_NONE), 1'b0);
		send_op(pack_op(OP_DIV, EXP_ZERO, DIR_POS, EXP_POS, DIR_NONE), 1'b0);
		send_op(pack_op(OP_DIV, EXP_NEG, DIR_NONE, EXP_NEG, DIR_POS), 1'b0);
		send_op(pack_op(OP_DIV, EXP_NEG, DIR_POS, EXP_POS, DIR_POS), 1'b0);
		send_op(pack_op(OP_DIV, EXP_POS, DIR_NEG, EXP_NEG, DIR_POS), 1'b0);
		send_op(pack_op(OP_DIV, EXP_ZERO, DIR_NONE, EXP_NEG, DIR_NEG), 1'b0);
		send_op(pack_op(OP_ADD, 2'd3, 2'd3, EXP_POS, DIR_POS), 1'b0);
		send_op(pack_op(OP_MUL, 2'd3, DIR_POS, EXP_NEG, 2'd3), 1'b0);
		send_op(pack_op(OP_DIV, EXP_ZERO, DIR_NEG, 2'd3, 2'd3), 1'b0);
		send_op('1, 1'b0);

		// Mostly legal codes, with a share of raw bit patterns; the middle stretch
		// runs back to back with no gaps.
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if ($urandom_range(0, 99) < 80)
				r = pack_op(2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)),
					2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
					2'($urandom_range(0, 2)));
			else
				r = req_t'(10'($urandom));
			send_op(r, !(i >= 250 && i < 450));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
